@@ hdl/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg: shortest path search shared definitions
// Field widths, command codes, word layouts and sequencer states.
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int VTX_W = 6;
	localparam int CNT_W = 7;

	localparam logic [CNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             command;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
		logic             edge_on;
	} item_t;

	typedef struct packed {
		logic [VTX_W-1:0] path_vertex;
		logic             found;
		logic             last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WR_RDA,
		ST_WR_WA,
		ST_WR_WB,
		ST_DEQ,
		ST_ROW_RD,
		ST_ROW,
		ST_SCAN,
		ST_WALK_EMIT,
		ST_WALK_RD,
		ST_EMIT_SRC,
		ST_EMIT_NF
	} state_t;

endpackage

@@ hdl/bsp_if.sv @@
// ----------------------------------------------------------------------------
// bsp_if: channel interfaces
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bsp_item_if;
	import bsp_pkg::*;

	logic             valid;
	logic             ready;
	logic             command;
	logic [VTX_W-1:0] vertex_a;
	logic [VTX_W-1:0] vertex_b;
	logic             edge_on;

	modport source (output valid, command, vertex_a, vertex_b, edge_on, input ready);
	modport sink (input valid, command, vertex_a, vertex_b, edge_on, output ready);
endinterface

interface bsp_result_if;
	import bsp_pkg::*;

	logic             valid;
	logic             ready;
	logic [VTX_W-1:0] path_vertex;
	logic             found;
	logic             last;

	modport source (output valid, path_vertex, found, last, input ready);
	modport sink (input valid, path_vertex, found, last, output ready);
endinterface

interface bsp_cfg_if;
	import bsp_pkg::*;

	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hdl/bfs_shortest_path.sv @@
// ----------------------------------------------------------------------------
// bfs_shortest_path: breadth-first shortest path unit
// Holds an undirected graph as an adjacency bit matrix, takes edge writes
// and path queries, and returns the path from destination back to source.
//
//   channel  dir  fields                                   word
//   item     in   command, vertex_a, vertex_b, edge_on     one edit or query
//   result   out  path_vertex, found, last                 one path vertex
//   cfg      in   data                                     vertex_count
//
// Edge write: two read-modify-writes of one port, in ST_WR_RDA, ST_WR_WA
// and ST_WR_WB. Query: each vertex taken from the search queue has its row
// read and its unvisited neighbours put in the queue, then the path is walked
// back one vertex at a time; the single adjacency memory port and the shared
// find-first unit set the pace. A rejected query returns one not-found result.
// Reset clears the adjacency valid bits at once; no clearing pass is needed.
// A result waits in an output register; a new result stalls while it is held.
// ----------------------------------------------------------------------------
module bfs_shortest_path #(
	parameter int MAX_VERTICES = 64
) (
	input  logic clk,
	input  logic arst_n,
	bsp_item_if.sink     item,
	bsp_result_if.source result,
	bsp_cfg_if.sink      cfg
);
	import bsp_pkg::*;

	logic [CNT_W-1:0] vertex_count_q;
	item_t            item_word;
	res_t             res, out_q;
	logic             res_valid, res_ready, out_valid_q, item_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
		end else if (cfg.valid) begin
			vertex_count_q <= cfg.data;
		end
	end

	assign item_word = '{command: item.command, vertex_a: item.vertex_a,
		vertex_b: item.vertex_b, edge_on: item.edge_on};
	assign item.ready = item_ready;

	bsp_search #(.MAX_VERTICES(MAX_VERTICES)) u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item_ready),
		.item         (item_word),
		.vertex_count (vertex_count_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.path_vertex = out_q.path_vertex;
	assign result.found       = out_q.found;
	assign result.last        = out_q.last;

endmodule

@@ hdl/bsp_pick.sv @@
// ----------------------------------------------------------------------------
// bsp_pick: find-first unit
// Isolates the lowest set bit of a candidate vector and encodes its index.
// ----------------------------------------------------------------------------
module bsp_pick #(
	parameter int W = 64
) (
	input  logic [W-1:0]         vec,
	output logic [W-1:0]         onehot,
	output logic [$clog2(W)-1:0] idx
);
	localparam int IW = $clog2(W);

	assign onehot = vec & (~vec + {{(W-1){1'b0}}, 1'b1});

	always_comb begin
		idx = '0;
		for (int i = 0; i < W; i++) begin
			if (onehot[i]) begin
				idx = idx | IW'(i);
			end
		end
	end

endmodule

@@ hdl/bsp_search.sv @@
// ----------------------------------------------------------------------------
// bsp_search: search engine
// Adjacency, queue and predecessor memories under a sequencer that does
// edge updates, the breadth-first scan and the walk back along the path.
// ----------------------------------------------------------------------------
module bsp_search #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  bsp_pkg::item_t        item,
	input  logic [bsp_pkg::CNT_W-1:0] vertex_count,
	output logic                  res_valid,
	input  logic                  res_ready,
	output bsp_pkg::res_t         res
);
	import bsp_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_VERTICES);

	state_t state_q, state_d;

	logic [VW-1:0]           a_q, b_q, v_q, cur_q;
	logic                    on_q;
	logic [CW-1:0]           head_q, tail_q;
	logic [MAX_VERTICES-1:0] visited_q, cand_q;

	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] adj_rdata_q;
	logic [MAX_VERTICES-1:0] adj_valid_q;
	logic                    adj_rvalid_q;
	logic [VW-1:0]           q_mem [MAX_VERTICES];
	logic [VW-1:0]           q_rdata_q;
	logic [VW-1:0]           pred_mem [MAX_VERTICES];
	logic [VW-1:0]           pred_rdata_q;

	logic                    adj_re, adj_we;
	logic [VW-1:0]           adj_raddr, adj_waddr;
	logic [MAX_VERTICES-1:0] adj_wdata;
	logic                    q_re, q_we;
	logic [VW-1:0]           q_raddr, q_waddr, q_wdata;
	logic                    pred_re, pred_we;
	logic [VW-1:0]           pred_raddr, pred_waddr, pred_wdata;

	logic [CNT_W-1:0]        n_act;
	logic [MAX_VERTICES-1:0] nmask, row_eff, cand;
	logic [MAX_VERTICES-1:0] pick_onehot;
	logic [VW-1:0]           pick_idx;
	logic                    in_acc, is_query, wr_ok, query_bad;

	bsp_pick #(.W(MAX_VERTICES)) u_pick (
		.vec    (cand_q),
		.onehot (pick_onehot),
		.idx    (pick_idx)
	);

	assign n_act = (vertex_count > MAXV) ? MAXV : vertex_count;

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			nmask[i] = (CNT_W'(i) < n_act);
		end
	end

	assign row_eff   = adj_rvalid_q ? adj_rdata_q : '0;
	assign cand      = row_eff & ~visited_q & nmask;
	assign in_acc    = item_valid && item_ready;
	assign is_query  = (item.command == CMD_QUERY);
	assign wr_ok     = (CNT_W'(item.vertex_a) < MAXV) && (CNT_W'(item.vertex_b) < MAXV);
	assign query_bad = (CNT_W'(item.vertex_a) >= n_act) || (CNT_W'(item.vertex_b) >= n_act)
		|| (item.vertex_a == item.vertex_b);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (is_query) begin
						state_d = query_bad ? ST_EMIT_NF : ST_DEQ;
					end else if (wr_ok) begin
						state_d = ST_WR_RDA;
					end
				end
			end
			ST_WR_RDA: state_d = ST_WR_WA;
			ST_WR_WA: state_d = ST_WR_WB;
			ST_WR_WB: state_d = ST_IDLE;
			ST_DEQ: state_d = (head_q == tail_q) ? ST_EMIT_NF : ST_ROW_RD;
			ST_ROW_RD: state_d = ST_ROW;
			ST_ROW: state_d = cand[b_q] ? ST_WALK_EMIT : ST_SCAN;
			ST_SCAN: begin
				if (cand_q == '0) begin
					state_d = ST_DEQ;
				end
			end
			ST_WALK_EMIT: begin
				if (res_ready) begin
					state_d = ST_WALK_RD;
				end
			end
			ST_WALK_RD: state_d = (pred_rdata_q == a_q) ? ST_EMIT_SRC : ST_WALK_EMIT;
			ST_EMIT_SRC, ST_EMIT_NF: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		res_valid  = 1'b0;
		res        = '0;
		adj_re     = 1'b0;
		adj_raddr  = a_q;
		adj_we     = 1'b0;
		adj_waddr  = a_q;
		adj_wdata  = row_eff;
		q_re       = 1'b0;
		q_raddr    = head_q[VW-1:0];
		q_we       = 1'b0;
		q_waddr    = tail_q[VW-1:0];
		q_wdata    = pick_idx;
		pred_re    = 1'b0;
		pred_raddr = cur_q;
		pred_we    = 1'b0;
		pred_waddr = pick_idx;
		pred_wdata = v_q;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				q_waddr    = '0;
				q_wdata    = item.vertex_a[VW-1:0];
				q_we       = item_valid && is_query && !query_bad;
			end
			ST_WR_RDA: begin
				adj_re = 1'b1;
			end
			ST_WR_WA: begin
				adj_we          = 1'b1;
				adj_wdata[b_q]  = on_q;
				adj_re          = 1'b1;
				adj_raddr       = b_q;
			end
			ST_WR_WB: begin
				adj_we          = 1'b1;
				adj_waddr       = b_q;
				adj_wdata[a_q]  = on_q;
			end
			ST_DEQ: begin
				q_re = (head_q != tail_q);
			end
			ST_ROW_RD: begin
				adj_re    = 1'b1;
				adj_raddr = q_rdata_q;
			end
			ST_ROW: begin
				pred_we    = cand[b_q];
				pred_waddr = b_q;
			end
			ST_SCAN: begin
				q_we    = (cand_q != '0);
				pred_we = (cand_q != '0);
			end
			ST_WALK_EMIT: begin
				res_valid = 1'b1;
				res       = '{path_vertex: VTX_W'(cur_q), found: 1'b1, last: 1'b0};
				pred_re   = res_ready;
			end
			ST_WALK_RD: begin
			end
			ST_EMIT_SRC: begin
				res_valid = 1'b1;
				res       = '{path_vertex: VTX_W'(a_q), found: 1'b1, last: 1'b1};
			end
			ST_EMIT_NF: begin
				res_valid = 1'b1;
				res       = '{path_vertex: '0, found: 1'b0, last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			visited_q    <= '0;
			cand_q       <= '0;
			adj_valid_q  <= '0;
			adj_rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adj_we) begin
				adj_valid_q[adj_waddr] <= 1'b1;
			end
			if (adj_re) begin
				adj_rvalid_q <= adj_valid_q[adj_raddr];
			end
			if (in_acc && is_query) begin
				head_q    <= '0;
				tail_q    <= CW'(1);
				visited_q <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << item.vertex_a[VW-1:0];
			end
			if (q_re) begin
				head_q <= head_q + CW'(1);
			end
			if (state_q == ST_ROW) begin
				cand_q <= cand;
			end
			if (state_q == ST_SCAN && cand_q != '0) begin
				tail_q    <= tail_q + CW'(1);
				visited_q <= visited_q | pick_onehot;
				cand_q    <= cand_q & ~pick_onehot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q  <= item.vertex_a[VW-1:0];
			b_q  <= item.vertex_b[VW-1:0];
			on_q <= item.edge_on;
		end
		if (state_q == ST_ROW_RD) begin
			v_q <= q_rdata_q;
		end
		if (state_q == ST_ROW) begin
			cur_q <= b_q;
		end
		if (state_q == ST_WALK_RD) begin
			cur_q <= pred_rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		if (adj_re) begin
			adj_rdata_q <= adj_mem[adj_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		if (q_re) begin
			q_rdata_q <= q_mem[q_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (pred_we) begin
			pred_mem[pred_waddr] <= pred_wdata;
		end
		if (pred_re) begin
			pred_rdata_q <= pred_mem[pred_raddr];
		end
	end

endmodule
